// File: hdl/mlfq_pkg.sv
// Shared types, constants and fixed-point helpers of the scheduler statistics unit.
// Used by mlfq_fixed_point_stats_unit; depends on nothing else.
`timescale 1ns / 1ps

package mlfq_pkg;

	// Table geometry (slot index is the low bits of the slot field)
	localparam int THREAD_SLOTS = 64;
	localparam int SLOT_BITS    = $clog2(THREAD_SLOTS);

	// Fixed-point format
	localparam int FRAC_BITS = 14;
	localparam int FONE      = 1 << FRAC_BITS;
	localparam int HALF      = FONE / 2;
	localparam int WORD      = 32;
	localparam int WIDE      = WORD + FRAC_BITS + 2;

	// Load average filter: la = (59/60) la + (1/60) n
	localparam int LA_MUL = (59 * FONE) / 60;
	localparam int LA_INC = FONE / 60;
	localparam int PCT    = 100;

	// Field widths
	localparam int PRIO_W = 8;
	localparam int NICE_W = 6;
	localparam int NICE_MAX = 20;
	localparam int NICE_MIN = -20;

	typedef enum logic [2:0] {
		ACT_LOAD     = 3'd0,
		ACT_DECAY    = 3'd1,
		ACT_PRIO     = 3'd2,
		ACT_SET_NICE = 3'd3,
		ACT_QUERY    = 3'd4,
		ACT_CLEAR    = 3'd5
	} action_t;

	typedef enum logic {
		REG_CEILING = 1'b0,
		REG_FLOOR   = 1'b1
	} reg_idx_t;

	// One row of the per-slot table
	typedef struct packed {
		logic signed [WORD-1:0]   rc;
		logic signed [NICE_W-1:0] nice;
		logic [PRIO_W-1:0]        prio;
	} entry_t;

	// x / F, truncated toward zero
	function automatic logic signed [WIDE-1:0] trunc_frac(input logic signed [WIDE-1:0] x);
		logic [WIDE-1:0] mag;
		mag = x[WIDE-1] ? WIDE'(-x) : WIDE'(x);
		mag = mag >> FRAC_BITS;
		trunc_frac = x[WIDE-1] ? -$signed(mag) : $signed(mag);
	endfunction

	// x / F, rounded to nearest, ties away from zero
	function automatic logic signed [WIDE-1:0] rnd_frac(input logic signed [WIDE-1:0] x);
		logic [WIDE-1:0] mag;
		mag = x[WIDE-1] ? WIDE'(-x) : WIDE'(x);
		mag = (mag + WIDE'(HALF)) >> FRAC_BITS;
		rnd_frac = x[WIDE-1] ? -$signed(mag) : $signed(mag);
	endfunction

	// Saturate to 32 bit signed
	function automatic logic signed [WORD-1:0] sat32(input logic signed [WIDE-1:0] x);
		logic signed [WIDE-1:0] hi;
		logic signed [WIDE-1:0] lo;
		hi = WIDE'(signed'({1'b0, {(WORD-1){1'b1}}}));
		lo = -hi - WIDE'(signed'(2'sb01));
		if (x > hi)
			sat32 = hi[WORD-1:0];
		else if (x < lo)
			sat32 = lo[WORD-1:0];
		else
			sat32 = x[WORD-1:0];
	endfunction

endpackage

// File: hdl/mlfq_fixed_point_stats_unit.sv
// Top level of the scheduler statistics unit: sequencer, slot table memory,
// iterative coefficient divider and fixed-point datapath. Depends on mlfq_pkg.
`timescale 1ns / 1ps

//  channel   ports                                            transaction marked by
//  ------    -----                                            ---------------------
//  command   action slot ready_count running_is_idle new_nice start & !busy at clk edge
//  result    priority_res nice load_avg_x100 recent_cpu_x100  done, one cycle
//  config    cfg_index cfg_wdata                              cfg_we at clk edge
//
// One command at a time. done is registered from the output state, after write back.
// The 14-step restoring divider for the decay coefficient makes decay and set nice
// the longest commands; query and clear are the shortest.
// busy is low again in the done cycle, so the next command may start there.
// Reset clears the slot table through per-slot valid bits at once; no sweep.
// The result side cannot stall: each result is marked by done for exactly one cycle.

module mlfq_fixed_point_stats_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// command
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 action,
	input  logic [5:0]                 slot,
	input  logic [6:0]                 ready_count,
	input  logic                       running_is_idle,
	input  logic signed [5:0]          new_nice,
	// result
	output logic                       done,
	output logic [7:0]                 priority_res,
	output logic signed [5:0]          nice,
	output logic signed [31:0]         load_avg_x100,
	output logic signed [31:0]         recent_cpu_x100,
	// configuration
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_wdata
);

	localparam int W   = mlfq_pkg::WIDE;
	localparam int FB  = mlfq_pkg::FRAC_BITS;
	localparam int SB  = mlfq_pkg::SLOT_BITS;
	localparam int CW  = $clog2(FB);
	localparam int LW  = mlfq_pkg::WORD + 1;   // 2 * load average
	localparam int DW  = mlfq_pkg::WORD + 2;   // divisor 2*la + F

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LA_MUL,
		ST_LA_ADD,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_PRIO,
		ST_WB,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0] ceiling_q;
	logic [7:0] floor_q;

	// latched command
	mlfq_pkg::action_t           act_q;
	logic [SB-1:0]               slot_q;
	logic [7:0]                  cnt_n_q;     // ready count plus running thread
	logic signed [5:0]           nn_q;        // clamped new nice

	// working copy of the slot entry and the load average
	logic signed [31:0]          la_q;
	logic signed [31:0]          rc_q;
	logic signed [5:0]           nice_q;
	logic [7:0]                  prio_q;

	// divider and multiplier
	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               den_q;
	logic [FB-1:0]               coef_q;
	logic [CW-1:0]               cnt_q;
	logic signed [W-1:0]         prod_q;
	logic signed [W-1:0]         la100_q;
	logic signed [W-1:0]         rc100_q;

	// slot table
	mlfq_pkg::entry_t            mem [mlfq_pkg::THREAD_SLOTS];
	mlfq_pkg::entry_t            rdata_q;
	logic                        rvalid_q;
	logic [mlfq_pkg::THREAD_SLOTS-1:0] valid_q;

	logic                        accept;
	logic                        mem_we;
	mlfq_pkg::entry_t            wdata;
	logic signed [5:0]           nn_sat;
	logic                        fetch_keep;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign mem_we = (state_q == ST_WB);

	// stored entry is used unless it was never written or the slot is cleared
	assign fetch_keep = rvalid_q && (act_q != mlfq_pkg::ACT_CLEAR);

	assign wdata.rc   = rc_q;
	assign wdata.nice = nice_q;
	assign wdata.prio = prio_q;

	// clamp of the incoming nice value
	always_comb begin
		if (new_nice > 6'(mlfq_pkg::NICE_MAX))
			nn_sat = 6'(mlfq_pkg::NICE_MAX);
		else if (new_nice < 6'(mlfq_pkg::NICE_MIN))
			nn_sat = 6'(mlfq_pkg::NICE_MIN);
		else
			nn_sat = new_nice;
	end

	// slot table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[slot_q] <= wdata;
		if (accept)
			rdata_q <= mem[slot[SB-1:0]];
	end

	// wide views of the working values
	logic signed [W-1:0] la_ext;
	logic signed [W-1:0] rc_ext;
	logic signed [W-1:0] nice_ext;
	logic signed [W-1:0] ceil_ext;
	logic signed [W-1:0] floor_ext;

	assign la_ext    = W'(la_q);
	assign rc_ext    = W'(rc_q);
	assign nice_ext  = W'(nice_q);
	assign ceil_ext  = signed'(W'(ceiling_q));
	assign floor_ext = signed'(W'(floor_q));

	// load average never goes negative, so 2*la is taken unsigned
	logic [LW-1:0] l_val;
	assign l_val = {la_q[30:0], 1'b0} & {1'b0, {(LW-1){!la_q[31]}}};

	// one restoring division step
	logic [DW:0]   rem_sh;
	logic          qbit;
	logic [DW:0]   rem_sub;
	assign rem_sh  = {rem_q, 1'b0};
	assign qbit    = (rem_sh >= {1'b0, den_q});
	assign rem_sub = rem_sh - {1'b0, den_q};

	// load average sum and decayed recent CPU
	logic signed [W-1:0] la_next;
	logic signed [W-1:0] rc_next;
	assign la_next = mlfq_pkg::trunc_frac(prod_q)
		+ W'(mlfq_pkg::LA_INC) * signed'(W'(cnt_n_q));
	assign rc_next = mlfq_pkg::trunc_frac(prod_q) + (nice_ext <<< FB);

	// priority: ceiling - round(rc/4 / F) - 2*nice, clamped
	logic [W-1:0]        q_mag;
	logic signed [W-1:0] q_val;
	logic signed [W-1:0] p_val;
	logic [7:0]          p_clamped;
	always_comb begin
		q_mag = rc_ext[W-1] ? W'(-rc_ext) : W'(rc_ext);
		q_mag = q_mag >> 2;
		q_val = rc_ext[W-1] ? -$signed(q_mag) : $signed(q_mag);
		p_val = ceil_ext - mlfq_pkg::rnd_frac(q_val) - (nice_ext <<< 1);
		if (p_val > ceil_ext)
			p_clamped = ceiling_q;
		else if (p_val < floor_ext)
			p_clamped = floor_q;
		else
			p_clamped = p_val[7:0];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= 8'd63;
			floor_q   <= 8'd0;
		end else if (cfg_we) begin
			unique case (mlfq_pkg::reg_idx_t'(cfg_index))
				mlfq_pkg::REG_CEILING: ceiling_q <= cfg_wdata;
				mlfq_pkg::REG_FLOOR:   floor_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// sequencer, datapath registers and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done     <= 1'b0;
			la_q     <= '0;
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			done <= (state_q == ST_OUT);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q    <= mlfq_pkg::action_t'(action);
						slot_q   <= slot[SB-1:0];
						cnt_n_q  <= {1'b0, ready_count} + 8'(!running_is_idle);
						nn_q     <= nn_sat;
						rvalid_q <= valid_q[slot[SB-1:0]];
						state_q  <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					// entries never written read as zero; clear zeroes the copy
					rc_q   <= fetch_keep ? rdata_q.rc   : '0;
					prio_q <= fetch_keep ? rdata_q.prio : '0;
					if (act_q == mlfq_pkg::ACT_SET_NICE)
						nice_q <= nn_q;
					else
						nice_q <= fetch_keep ? rdata_q.nice : '0;
					rem_q  <= DW'(l_val);
					den_q  <= DW'(l_val) + DW'(mlfq_pkg::FONE);
					cnt_q  <= '0;
					case (act_q)
						mlfq_pkg::ACT_LOAD:     state_q <= ST_LA_MUL;
						mlfq_pkg::ACT_DECAY:    state_q <= ST_DIV;
						mlfq_pkg::ACT_PRIO:     state_q <= ST_PRIO;
						mlfq_pkg::ACT_SET_NICE: state_q <= ST_DIV;
						default:                state_q <= ST_WB;
					endcase
				end
				ST_LA_MUL: begin
					prod_q  <= la_ext * W'(mlfq_pkg::LA_MUL);
					state_q <= ST_LA_ADD;
				end
				ST_LA_ADD: begin
					la_q    <= mlfq_pkg::sat32(la_next);
					state_q <= ST_WB;
				end
				ST_DIV: begin
					// coef = 2la*F / (2la+F), one quotient bit a cycle
					rem_q  <= qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
					coef_q <= {coef_q[FB-2:0], qbit};
					cnt_q  <= cnt_q + CW'(1);
					if (cnt_q == CW'(FB - 1))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= signed'(W'(coef_q)) * rc_ext;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					rc_q    <= mlfq_pkg::sat32(rc_next);
					state_q <= (act_q == mlfq_pkg::ACT_SET_NICE) ? ST_PRIO : ST_WB;
				end
				ST_PRIO: begin
					prio_q  <= p_clamped;
					state_q <= ST_WB;
				end
				ST_WB: begin
					valid_q[slot_q] <= 1'b1;
					la100_q <= la_ext * W'(mlfq_pkg::PCT);
					rc100_q <= rc_ext * W'(mlfq_pkg::PCT);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					priority_res    <= prio_q;
					nice            <= nice_q;
					load_avg_x100   <= mlfq_pkg::sat32(mlfq_pkg::rnd_frac(la100_q));
					recent_cpu_x100 <= mlfq_pkg::sat32(mlfq_pkg::rnd_frac(rc100_q));
					state_q         <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/mlfq_chk.sv
// Port-level checker for the scheduler statistics unit, with its bind.
// Depends on the ports of mlfq_fixed_point_stats_unit only.
`timescale 1ns / 1ps

module mlfq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic signed [5:0] nice
);

	// an accepted command makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// the unit does not get busy on its own
	a_no_spurious_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !busy)
		else $error("busy rose without a transaction");

	// one result per command, and the unit is free when it appears
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of a transaction");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// stored nice stays within its legal range
	a_nice_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (nice >= -6'sd20) && (nice <= 6'sd20))
		else $error("nice result out of range");

endmodule

bind mlfq_fixed_point_stats_unit mlfq_chk u_mlfq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.nice   (nice)
);
